// ===== src/register_write_stream_compactor_macros.svh =====
// Assertion macros for the compactor checker
`ifndef REGISTER_WRITE_STREAM_COMPACTOR_MACROS_SVH
`define REGISTER_WRITE_STREAM_COMPACTOR_MACROS_SVH

`define RWSC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define RWSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rwsc_pkg.sv =====
package rwsc_pkg;

    localparam logic [7:0] RETRIG_BD = 8'hBD;
    localparam logic [7:0] RETRIG_LO = 8'hB0;
    localparam logic [7:0] RETRIG_HI = 8'hB8;

    localparam logic [1:0] REG_QUANT_GRID = 2'd0;
    localparam logic [1:0] REG_DEDUP      = 2'd1;
    localparam logic [1:0] REG_KEEP_RETRG = 2'd2;

    // front to back queue entry
    typedef struct packed {
        logic        flush;
        logic [31:0] time_ms;
        logic [8:0]  reg_addr;
        logic [7:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [8:0]  reg_addr;
        logic [7:0]  value;
        logic        last_of_run;
        logic        overflow;
    } res_t;

    typedef struct packed {
        logic [15:0] quant_grid;
        logic        dedup_enable;
        logic        retrig_exempt;
    } cfg_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_SHRD,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CHECK,
        BK_SCAN,
        BK_SCAN_RD,
        BK_EMIT,
        BK_EMIT_RD,
        BK_EMIT_WR,
        BK_EMIT_LAST,
        BK_CLEAR,
        BK_DIRECT,
        BK_DIRECT_WR,
        BK_APPEND
    } back_state_t;

    function automatic logic is_retrig(input logic [8:0] r);
        is_retrig = (r == {1'b0, RETRIG_BD}) ||
                    ((r[7:0] >= RETRIG_LO) && (r[7:0] <= RETRIG_HI));
    endfunction

endpackage

// ===== src/rwsc_ram.sv =====
module rwsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/rwsc_front.sv =====
module rwsc_front #(
    parameter int REG_SPACE = 512
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rwsc_pkg::cfg_t  cfg,
    input  logic            clr_active,
    input  logic [8:0]      clr_addr,
    input  logic            push,
    output logic            full,
    input  logic            kind,
    input  logic [31:0]     time_ms,
    input  logic [8:0]      reg_addr,
    input  logic [7:0]      value,
    output logic            q_push,
    input  logic            q_full,
    output rwsc_pkg::cmd_t  q_data
);

    rwsc_pkg::front_state_t state_reg, state_next;
    rwsc_pkg::cmd_t         cmd_reg, cmd_next;
    logic [32:0]            rem_reg, rem_next;
    logic [31:0]            quo_reg, quo_next;
    logic [31:0]            sum_reg, sum_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [7:0]             shd_rdata;
    logic                   shd_we;
    logic [8:0]             shd_waddr;
    logic [7:0]             shd_wdata;
    logic                   in_space;
    logic                   accept;
    logic [32:0]            trial;
    logic [31:0]            prod;
    logic                   quant;

    assign accept   = push && !full;
    assign in_space = ({23'd0, cmd_reg.reg_addr} < REG_SPACE);
    assign quant    = (cfg.quant_grid > 16'd1);
    assign trial    = {rem_reg[31:0], sum_reg[31]} - {17'd0, cfg.quant_grid};
    assign prod     = quo_reg * {16'd0, cfg.quant_grid};

    rwsc_ram #(.WIDTH(8), .DEPTH(512)) u_shadow (
        .clk   (clk),
        .we    (shd_we),
        .waddr (shd_waddr),
        .wdata (shd_wdata),
        .raddr (reg_addr),
        .rdata (shd_rdata)
    );

    always_comb
    begin
        full   = (state_reg != rwsc_pkg::FR_IDLE) || clr_active;
        q_push = (state_reg == rwsc_pkg::FR_PUSH);
        q_data = cmd_reg;
        shd_we    = clr_active;
        shd_waddr = clr_addr;
        shd_wdata = 8'd0;
        if (!clr_active && state_reg == rwsc_pkg::FR_SHRD && !cmd_reg.flush
            && in_space && shd_rdata != cmd_reg.value)
        begin
            shd_we    = 1'b1;
            shd_waddr = cmd_reg.reg_addr;
            shd_wdata = cmd_reg.value;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            rwsc_pkg::FR_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = '{flush: kind, time_ms: time_ms, reg_addr: reg_addr,
                                   value: value};
                    state_next = rwsc_pkg::FR_SHRD;
                end
            end
            rwsc_pkg::FR_SHRD:
            begin
                if (cmd_reg.flush)
                begin
                    state_next = rwsc_pkg::FR_PUSH;
                end
                else if (in_space && shd_rdata == cmd_reg.value)
                begin
                    state_next = rwsc_pkg::FR_IDLE;
                end
                else if (quant)
                begin
                    sum_next   = cmd_reg.time_ms + {17'd0, cfg.quant_grid[15:1]};
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = rwsc_pkg::FR_DIV;
                end
                else
                begin
                    state_next = rwsc_pkg::FR_PUSH;
                end
            end
            rwsc_pkg::FR_DIV:
            begin
                if (cnt_reg == 6'd32)
                begin
                    cmd_next.time_ms = prod;
                    state_next       = rwsc_pkg::FR_PUSH;
                end
                else
                begin
                    if (!trial[32])
                    begin
                        rem_next = trial;
                        quo_next = {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_reg[31:0], sum_reg[31]};
                        quo_next = {quo_reg[30:0], 1'b0};
                    end
                    sum_next = {sum_reg[30:0], 1'b0};
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            rwsc_pkg::FR_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = rwsc_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = rwsc_pkg::FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwsc_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        sum_reg <= sum_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ===== src/rwsc_queue.sv =====
module rwsc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  rwsc_pkg::cmd_t wdata,
    output logic           full,
    input  logic           rd,
    output rwsc_pkg::cmd_t rdata,
    output logic           empty
);

    rwsc_pkg::cmd_t mem_reg [2];
    logic [1:0]     cnt_reg;
    logic           wp_reg;
    logic           rp_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (wr && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, (wr && !full)} - {1'b0, (rd && !empty)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== src/rwsc_back.sv =====
module rwsc_back #(
    parameter int TICK_DEPTH = 32,
    parameter int REG_SPACE  = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rwsc_pkg::cfg_t cfg,
    input  logic           clr_active,
    input  logic [8:0]     clr_addr,
    input  logic           q_empty,
    input  rwsc_pkg::cmd_t q_data,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output rwsc_pkg::res_t res
);

    localparam int IW = $clog2(TICK_DEPTH);
    localparam int CW = $clog2(TICK_DEPTH + 1);

    rwsc_pkg::back_state_t   state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [31:0]             ttime_reg, ttime_next;
    logic [TICK_DEPTH-1:0]   keep_reg, keep_next;
    logic [8:0]              tb_reg_a [TICK_DEPTH];
    logic [7:0]              tb_val   [TICK_DEPTH];
    logic                    ovf_reg, ovf_next;
    logic                    pend_reg, pend_next;
    rwsc_pkg::cmd_t          cmd_reg, cmd_next;
    logic                    hold_vld_reg, hold_vld_next;
    logic [8:0]              hold_addr_reg, hold_addr_next;
    logic [7:0]              hold_val_reg, hold_val_next;
    logic                    tb_we;

    logic        seen_we;
    logic [8:0]  seen_waddr;
    logic        seen_wdata;
    logic [8:0]  seen_raddr;
    logic [0:0]  seen_rdata;
    logic        sh_we;
    logic [8:0]  sh_waddr;
    logic [7:0]  sh_wdata;
    logic [8:0]  sh_raddr;
    logic [7:0]  sh_rdata;
    logic [8:0]  ent_r;
    logic [7:0]  ent_v;
    logic        ent_space;
    logic [IW-1:0] ent_idx;
    logic [IW-1:0] scan_idx;
    logic [8:0]    scan_r;

    rwsc_ram #(.WIDTH(1), .DEPTH(512)) u_seen (
        .clk(clk), .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
        .raddr(seen_raddr), .rdata(seen_rdata)
    );

    rwsc_ram #(.WIDTH(8), .DEPTH(512)) u_shadow2 (
        .clk(clk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
        .raddr(sh_raddr), .rdata(sh_rdata)
    );

    assign ent_idx   = idx_reg[IW-1:0];
    assign ent_r     = tb_reg_a[ent_idx];
    assign ent_v     = tb_val[ent_idx];
    assign ent_space = ({23'd0, ent_r} < REG_SPACE);
    assign scan_idx  = IW'(idx_reg - CW'(1));
    assign scan_r    = tb_reg_a[scan_idx];
    assign tb_we     = (state_reg == rwsc_pkg::BK_APPEND);

    always_comb
    begin
        seen_we    = clr_active;
        seen_waddr = clr_addr;
        seen_wdata = 1'b0;
        sh_we      = clr_active;
        sh_waddr   = clr_addr;
        sh_wdata   = 8'd0;
        seen_raddr = scan_r;
        sh_raddr   = ent_r;
        if (state_reg == rwsc_pkg::BK_DIRECT)
        begin
            sh_raddr = cmd_reg.reg_addr;
        end
        if (!clr_active)
        begin
            unique case (state_reg)
                rwsc_pkg::BK_SCAN_RD:
                begin
                    if (ent_space && !(cfg.retrig_exempt && rwsc_pkg::is_retrig(ent_r))
                        && !seen_rdata[0])
                    begin
                        seen_we    = 1'b1;
                        seen_waddr = ent_r;
                        seen_wdata = 1'b1;
                    end
                end
                rwsc_pkg::BK_CLEAR:
                begin
                    seen_we    = 1'b1;
                    seen_waddr = ent_r;
                    seen_wdata = 1'b0;
                end
                rwsc_pkg::BK_EMIT_RD:
                begin
                    if (ent_space && sh_rdata != ent_v)
                    begin
                        sh_we    = 1'b1;
                        sh_waddr = ent_r;
                        sh_wdata = ent_v;
                    end
                end
                rwsc_pkg::BK_DIRECT:
                begin
                    if ({23'd0, cmd_reg.reg_addr} < REG_SPACE)
                    begin
                        sh_we    = 1'b1;
                        sh_waddr = cmd_reg.reg_addr;
                        sh_wdata = cmd_reg.value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ttime_next     = ttime_reg;
        keep_next      = keep_reg;
        ovf_next       = ovf_reg;
        pend_next      = pend_reg;
        cmd_next       = cmd_reg;
        hold_vld_next  = hold_vld_reg;
        hold_addr_next = hold_addr_reg;
        hold_val_next  = hold_val_reg;
        q_pop          = 1'b0;
        res_valid      = 1'b0;
        res            = '{time_ms: ttime_reg, reg_addr: hold_addr_reg, value: hold_val_reg,
                           last_of_run: 1'b0, overflow: ovf_reg};
        unique case (state_reg)
            rwsc_pkg::BK_IDLE:
            begin
                if (!q_empty && !clr_active)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = rwsc_pkg::BK_CHECK;
                end
            end
            rwsc_pkg::BK_CHECK:
            begin
                ovf_next = 1'b0;
                if (cmd_reg.flush)
                begin
                    pend_next = 1'b0;
                    state_next = (count_reg != '0) ? rwsc_pkg::BK_SCAN : rwsc_pkg::BK_IDLE;
                    idx_next   = count_reg;
                end
                else if (!cfg.dedup_enable)
                begin
                    pend_next  = 1'b1;
                    idx_next   = count_reg;
                    state_next = (count_reg != '0) ? rwsc_pkg::BK_SCAN : rwsc_pkg::BK_DIRECT;
                end
                else if (count_reg != '0 && cmd_reg.time_ms != ttime_reg)
                begin
                    pend_next  = 1'b1;
                    idx_next   = count_reg;
                    state_next = rwsc_pkg::BK_SCAN;
                end
                else
                begin
                    state_next = rwsc_pkg::BK_APPEND;
                end
            end
            rwsc_pkg::BK_APPEND:
            begin
                if (count_reg == '0)
                begin
                    ttime_next = cmd_reg.time_ms;
                end
                count_next = count_reg + CW'(1);
                if (count_reg + CW'(1) == CW'(TICK_DEPTH))
                begin
                    ovf_next   = 1'b1;
                    pend_next  = 1'b0;
                    idx_next   = CW'(TICK_DEPTH);
                    state_next = rwsc_pkg::BK_SCAN;
                end
                else
                begin
                    state_next = rwsc_pkg::BK_IDLE;
                end
            end
            rwsc_pkg::BK_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = rwsc_pkg::BK_EMIT;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = rwsc_pkg::BK_SCAN_RD;
                end
            end
            rwsc_pkg::BK_SCAN_RD:
            begin
                if (ent_space && !(cfg.retrig_exempt && rwsc_pkg::is_retrig(ent_r))
                    && seen_rdata[0])
                begin
                    keep_next[ent_idx] = 1'b0;
                end
                state_next = rwsc_pkg::BK_SCAN;
            end
            rwsc_pkg::BK_EMIT:
            begin
                if (idx_reg == count_reg)
                begin
                    if (hold_vld_reg)
                    begin
                        state_next = rwsc_pkg::BK_EMIT_LAST;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = rwsc_pkg::BK_CLEAR;
                    end
                end
                else if (!keep_reg[ent_idx])
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = rwsc_pkg::BK_EMIT_RD;
                end
            end
            rwsc_pkg::BK_EMIT_RD:
            begin
                if (ent_space && sh_rdata == ent_v)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = rwsc_pkg::BK_EMIT;
                end
                else
                begin
                    state_next = rwsc_pkg::BK_EMIT_WR;
                end
            end
            rwsc_pkg::BK_EMIT_WR:
            begin
                res_valid = hold_vld_reg;
                if (!hold_vld_reg || res_ready)
                begin
                    hold_vld_next  = 1'b1;
                    hold_addr_next = ent_r;
                    hold_val_next  = ent_v;
                    idx_next       = idx_reg + CW'(1);
                    state_next     = rwsc_pkg::BK_EMIT;
                end
            end
            rwsc_pkg::BK_EMIT_LAST:
            begin
                res_valid       = 1'b1;
                res.last_of_run = !(pend_reg && !cfg.dedup_enable);
                if (res_ready)
                begin
                    hold_vld_next = 1'b0;
                    idx_next      = '0;
                    state_next    = rwsc_pkg::BK_CLEAR;
                end
            end
            rwsc_pkg::BK_CLEAR:
            begin
                if (idx_reg + CW'(1) >= count_reg)
                begin
                    count_next = '0;
                    keep_next  = '1;
                    idx_next   = '0;
                    ovf_next   = 1'b0;
                    if (pend_reg && !cfg.dedup_enable)
                    begin
                        state_next = rwsc_pkg::BK_DIRECT;
                    end
                    else if (pend_reg)
                    begin
                        state_next = rwsc_pkg::BK_APPEND;
                    end
                    else
                    begin
                        state_next = rwsc_pkg::BK_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            rwsc_pkg::BK_DIRECT:
            begin
                state_next = rwsc_pkg::BK_DIRECT_WR;
            end
            rwsc_pkg::BK_DIRECT_WR:
            begin
                res_valid = 1'b1;
                res = '{time_ms: cmd_reg.time_ms, reg_addr: cmd_reg.reg_addr,
                        value: cmd_reg.value, last_of_run: 1'b1, overflow: 1'b0};
                if (res_ready)
                begin
                    state_next = rwsc_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rwsc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rwsc_pkg::BK_IDLE;
            count_reg    <= '0;
            ttime_reg    <= '0;
            keep_reg     <= '1;
            ovf_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            idx_reg      <= '0;
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ttime_reg    <= ttime_next;
            keep_reg     <= keep_next;
            ovf_reg      <= ovf_next;
            pend_reg     <= pend_next;
            idx_reg      <= idx_next;
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        hold_addr_reg <= hold_addr_next;
        hold_val_reg  <= hold_val_next;
        if (tb_we)
        begin
            tb_reg_a[count_reg[IW-1:0]] <= cmd_reg.reg_addr;
            tb_val[count_reg[IW-1:0]]   <= cmd_reg.value;
        end
    end

endmodule

// ===== src/rwsc_outbuf.sv =====
module rwsc_outbuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rwsc_pkg::res_t in_data,
    output logic           empty,
    input  logic           pop,
    output rwsc_pkg::res_t out_data
);

    logic           vld_reg;
    rwsc_pkg::res_t dat_reg;

    assign empty    = !vld_reg;
    assign in_ready = !vld_reg || pop;
    assign out_data = dat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dat_reg <= in_data;
        end
    end

endmodule

// ===== src/register_write_stream_compactor.sv =====
// Register write stream compactor.
// Input queue port: present kind/time_ms/reg_addr/value with push; the beat is
// taken when full is low. Result queue port: while empty is low the oldest result
// is on out_time_ms/out_reg_addr/out_value/last_of_run/overflow; pop takes it.
// Configuration over APB: 0x0 quant_grid, 0x4 dedup_enable, 0x8 retrig_exempt.
// Front: shadow compare then, for quant_grid above 1, a 32-step radix-2 divider for
// time rounding; a write equal to the front shadow is dropped, and full stays high
// until the write is pushed or dropped. A two-entry queue separates front and back.
// Back: with dedup off each write goes straight to the result side. A tick close
// walks the buffer backward and marks older writes to a register seen later as
// dropped (retrigger registers exempt if retrig_exempt is set), then forward:
// dropped entries are skipped, the rest are checked against the second shadow,
// each changed one becomes a result and the final result of the run goes out last;
// then a clear sweep runs over the entries.
// After reset both shadows and the seen map are cleared by a sweep over all 512
// addresses; full stays high meanwhile. When pop is held low the output register
// and the back stall; the queue then fills and full rises toward the input side.
module register_write_stream_compactor #(
    parameter int TICK_DEPTH = 32,
    parameter int REG_SPACE  = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [31:0] time_ms,
    input  logic [8:0]  reg_addr,
    input  logic [7:0]  value,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] out_time_ms,
    output logic [8:0]  out_reg_addr,
    output logic [7:0]  out_value,
    output logic        last_of_run,
    output logic        overflow
);

    rwsc_pkg::cfg_t cfg_reg;
    logic           clr_active_reg;
    logic [8:0]     clr_addr_reg;
    logic           q_push, q_full, q_pop, q_empty;
    rwsc_pkg::cmd_t q_wdata, q_rdata;
    logic           res_valid, res_ready;
    rwsc_pkg::res_t res, res_out;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            rwsc_pkg::REG_QUANT_GRID: prdata = {16'd0, cfg_reg.quant_grid};
            rwsc_pkg::REG_DEDUP:      prdata = {31'd0, cfg_reg.dedup_enable};
            rwsc_pkg::REG_KEEP_RETRG: prdata = {31'd0, cfg_reg.retrig_exempt};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '{quant_grid: 16'd0, dedup_enable: 1'b0, retrig_exempt: 1'b1};
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 9'd1;
                if (clr_addr_reg == 9'h1FF)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (wr_en && paddr[1:0] == 2'd0)
            begin
                unique case (paddr[3:2])
                    rwsc_pkg::REG_QUANT_GRID: cfg_reg.quant_grid    <= pwdata[15:0];
                    rwsc_pkg::REG_DEDUP:      cfg_reg.dedup_enable  <= pwdata[0];
                    rwsc_pkg::REG_KEEP_RETRG: cfg_reg.retrig_exempt <= pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    rwsc_front #(.REG_SPACE(REG_SPACE)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .clr_active(clr_active_reg), .clr_addr(clr_addr_reg),
        .push(push), .full(full), .kind(kind), .time_ms(time_ms),
        .reg_addr(reg_addr), .value(value),
        .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
    );

    rwsc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(q_push), .wdata(q_wdata), .full(q_full),
        .rd(q_pop), .rdata(q_rdata), .empty(q_empty)
    );

    rwsc_back #(.TICK_DEPTH(TICK_DEPTH), .REG_SPACE(REG_SPACE)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .clr_active(clr_active_reg), .clr_addr(clr_addr_reg),
        .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    rwsc_outbuf u_outbuf (
        .clk(clk), .rst_n(rst_n), .in_valid(res_valid), .in_ready(res_ready),
        .in_data(res), .empty(empty), .pop(pop), .out_data(res_out)
    );

    assign out_time_ms  = res_out.time_ms;
    assign out_reg_addr = res_out.reg_addr;
    assign out_value    = res_out.value;
    assign last_of_run  = res_out.last_of_run;
    assign overflow     = res_out.overflow;

endmodule

// ===== src/rwsc_checker.sv =====
`include "register_write_stream_compactor_macros.svh"

module rwsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] out_time_ms,
    input logic [8:0]  out_reg_addr,
    input logic [7:0]  out_value,
    input logic        last_of_run,
    input logic        overflow
);

    `RWSC_ASSERT_NEXT(a_hold_result, clk, rst_n, !empty && !pop, !empty && $stable(out_time_ms) && $stable(out_reg_addr) && $stable(out_value) && $stable(last_of_run) && $stable(overflow), "result changed while stalled")
    `RWSC_ASSERT_NEXT(a_full_after_accept, clk, rst_n, push && !full, full, "input taken twice in a row")
    `RWSC_ASSERT_NEXT(a_ovf_time_same, clk, rst_n, !empty && pop && overflow && !last_of_run, empty || (overflow && out_time_ms == $past(out_time_ms)), "time changed inside one overflow run")
    `RWSC_ASSERT(a_known_result, clk, rst_n, !empty |-> !$isunknown({out_time_ms, out_reg_addr, out_value, last_of_run, overflow}), "unknown bits on a waiting result")

endmodule

bind register_write_stream_compactor rwsc_checker u_rwsc_checker (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
    .out_time_ms(out_time_ms), .out_reg_addr(out_reg_addr), .out_value(out_value),
    .last_of_run(last_of_run), .overflow(overflow)
);

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    class compactor_scoreboard;
        bit [15:0] grid;
        bit        dedup_on;
        bit        keep_retrig;
        bit [7:0]  shadow_a [512];
        bit [7:0]  shadow_b [512];
        bit [8:0]  buf_addr [32];
        bit [7:0]  buf_val [32];
        int        buf_cnt;
        bit [31:0] buf_time;
        rwsc_pkg::res_t expected_q [$];
        int        errors;

        function void init();
            grid = 0;
            dedup_on = 0;
            keep_retrig = 1;
            foreach (shadow_a[i]) shadow_a[i] = 0;
            foreach (shadow_b[i]) shadow_b[i] = 0;
            buf_cnt = 0;
            buf_time = 0;
            expected_q.delete();
            errors = 0;
        endfunction

        function bit is_retrigger(bit [8:0] r);
            return r == 9'h0BD || (r[7:0] >= 8'hB0 && r[7:0] <= 8'hB8);
        endfunction

        function void add_result(bit [31:0] t, bit [8:0] r, bit [7:0] v, bit ovf);
            rwsc_pkg::res_t e;
            e.time_ms = t;
            e.reg_addr = r;
            e.value = v;
            e.last_of_run = 0;
            e.overflow = ovf;
            expected_q.push_back(e);
        endfunction

        function void close_tick(bit ovf);
            bit seen [512];
            bit drop [32];
            bit [8:0] r;
            bit [7:0] v;
            foreach (seen[i]) seen[i] = 0;
            foreach (drop[i]) drop[i] = 0;
            for (int k = buf_cnt - 1; k >= 0; k--) begin
                r = buf_addr[k];
                if (keep_retrig && is_retrigger(r))
                    continue;
                if (seen[r])
                    drop[k] = 1;
                else
                    seen[r] = 1;
            end
            for (int k = 0; k < buf_cnt; k++) begin
                r = buf_addr[k];
                v = buf_val[k];
                if (drop[k] || shadow_b[r] == v)
                    continue;
                shadow_b[r] = v;
                add_result(buf_time, r, v, ovf);
            end
            buf_cnt = 0;
        endfunction

        function void note_input(bit k, bit [31:0] t, bit [8:0] r, bit [7:0] v);
            int before_n;
            bit [31:0] s;
            before_n = expected_q.size();
            if (k) begin
                if (buf_cnt > 0)
                    close_tick(0);
            end else if (shadow_a[r] != v) begin
                shadow_a[r] = v;
                if (grid > 1) begin
                    s = t + (grid >> 1);
                    t = (s / grid) * grid;
                end
                if (dedup_on) begin
                    if (buf_cnt > 0 && t != buf_time)
                        close_tick(0);
                    if (buf_cnt == 0)
                        buf_time = t;
                    buf_addr[buf_cnt] = r;
                    buf_val[buf_cnt] = v;
                    buf_cnt++;
                    if (buf_cnt >= 32)
                        close_tick(1);
                end else begin
                    if (buf_cnt > 0)
                        close_tick(0);
                    shadow_b[r] = v;
                    add_result(t, r, v, 0);
                end
            end
            if (expected_q.size() > before_n)
                expected_q[expected_q.size() - 1].last_of_run = 1;
        endfunction

        function void check_result(rwsc_pkg::res_t got);
            rwsc_pkg::res_t e;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat: time %0h reg %0h value %0h",
                       got.time_ms, got.reg_addr, got.value);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.time_ms !== e.time_ms) begin
                $error("out_time_ms expected %0h actual %0h", e.time_ms, got.time_ms);
                errors++;
            end
            if (got.reg_addr !== e.reg_addr) begin
                $error("out_reg_addr expected %0h actual %0h", e.reg_addr, got.reg_addr);
                errors++;
            end
            if (got.value !== e.value) begin
                $error("out_value expected %0h actual %0h", e.value, got.value);
                errors++;
            end
            if (got.last_of_run !== e.last_of_run) begin
                $error("last_of_run expected %0b actual %0b", e.last_of_run, got.last_of_run);
                errors++;
            end
            if (got.overflow !== e.overflow) begin
                $error("overflow expected %0b actual %0b", e.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic        kind;
    logic [31:0] time_ms;
    logic [8:0]  reg_addr;
    logic [7:0]  value;
    logic        empty;
    logic        pop;
    logic [31:0] out_time_ms;
    logic [8:0]  out_reg_addr;
    logic [7:0]  out_value;
    logic        last_of_run;
    logic        overflow;

    compactor_scoreboard sb;
    int        burst_left;
    int        pop_rate;
    int        idle_cycles;
    bit [31:0] cur_time;
    bit [8:0]  addr_pool [8];

    register_write_stream_compactor u_top (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        case (idx)
            rwsc_pkg::REG_QUANT_GRID: sb.grid = data[15:0];
            rwsc_pkg::REG_DEDUP:      sb.dedup_on = data[0];
            default:                  sb.keep_retrig = data[0];
        endcase
    endtask

    task automatic configure(logic [15:0] g, logic d, logic k);
        write_reg(rwsc_pkg::REG_QUANT_GRID, {16'h0, g});
        write_reg(rwsc_pkg::REG_DEDUP, {31'h0, d});
        write_reg(rwsc_pkg::REG_KEEP_RETRG, {31'h0, k});
    endtask

    task automatic wait_drained();
        push <= 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic send(logic k, logic [31:0] t, logic [8:0] r, logic [7:0] v);
        if (burst_left == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        push     <= 1;
        kind     <= k;
        time_ms  <= t;
        reg_addr <= r;
        value    <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_input(k, t, r, v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pop && !empty)
                sb.check_result('{out_time_ms, out_reg_addr, out_value,
                                  last_of_run, overflow});
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if ($urandom_range(0, 199) == 0)
                pop_rate <= ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
            pop <= ($urandom_range(0, 99) < pop_rate);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles > 30000) begin
            $display("register_write_stream_compactor test failed");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.init();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        push = 0;
        kind = 0;
        time_ms = 0;
        reg_addr = 0;
        value = 0;
        pop = 0;
        pop_rate = 100;
        idle_cycles = 0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;

        send(1'b0, 32'h0, 9'h000, 8'hFF);
        send(1'b0, 32'hFFFF_FFFF, 9'h1FF, 8'h80);
        send(1'b0, 32'hFFFF_FFFF, 9'h1FF, 8'h80);
        send(1'b1, 32'h0, 9'h0, 8'h0);
        send(1'b0, 32'h10, 9'h0AA, 8'h55);
        wait_drained();

        configure(16'd3, 1'b1, 1'b1);
        send(1'b0, 32'hFFFF_FFFF, 9'h0BD, 8'h01);
        send(1'b0, 32'hFFFF_FFFF, 9'h0BD, 8'h02);
        send(1'b0, 32'hFFFF_FFFE, 9'h1B8, 8'h03);
        send(1'b0, 32'hFFFF_FFFE, 9'h1B8, 8'h04);
        send(1'b0, 32'hFFFF_FFFE, 9'h020, 8'h05);
        send(1'b0, 32'hFFFF_FFFF, 9'h020, 8'h06);
        send(1'b0, 32'h0000_0000, 9'h020, 8'h05);
        send(1'b0, 32'h0000_0100, 9'h0B0, 8'h07);
        send(1'b1, 32'h0, 9'h0, 8'h0);
        send(1'b1, 32'h0, 9'h0, 8'h0);
        wait_drained();

        configure(16'hFFFF, 1'b1, 1'b0);
        send(1'b0, 32'h5, 9'h0BD, 8'h11);
        send(1'b0, 32'h6, 9'h0BD, 8'h12);
        send(1'b0, 32'h7, 9'h0BD, 8'h11);
        for (int i = 0; i < 33; i++)
            send(1'b0, 32'h9, 9'(9'h100 + i), 8'(8'hC0 + i));
        send(1'b0, 32'h0, 9'h1B5, 8'h01);
        wait_drained();

        addr_pool = '{9'h0BD, 9'h0B0, 9'h1B8, 9'h0B9, 9'h001, 9'h101, 9'h040, 9'h1FF};
        cur_time = $urandom();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: configure(16'd0, 1'b1, 1'b1);
                1: configure(16'd1, 1'b0, 1'b1);
                2: configure(16'hFFFF, 1'b1, 1'b1);
                3: configure(16'd2, 1'b1, 1'b0);
                default: configure(16'($urandom_range(0, 40)), 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
            endcase
            for (int i = 0; i < 10; i++) begin
                int sel;
                sel = $urandom_range(0, 99);
                if (sel < 6) begin
                    send(1'b1, $urandom(), 9'($urandom()), 8'($urandom()));
                end else if (sel < 8 && sb.dedup_on) begin
                    for (int j = 0; j < 32; j++)
                        send(1'b0, cur_time, 9'($urandom_range(0, 511)), 8'($urandom()));
                end else begin
                    if ($urandom_range(0, 2) == 0)
                        cur_time += $urandom_range(0, 2 * sb.grid + 4);
                    else if ($urandom_range(0, 30) == 0)
                        cur_time = $urandom();
                    send(1'b0, cur_time,
                         ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                     : addr_pool[$urandom_range(0, 7)],
                         ($urandom_range(0, 3) == 0) ? 8'($urandom())
                                                     : 8'($urandom_range(0, 3)));
                end
            end
            send(1'b1, 32'h0, 9'h0, 8'h0);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("register_write_stream_compactor test passed");
        else
            $display("register_write_stream_compactor test failed");
        $finish;
    end
endmodule
